FILE: rtl/qaas_pkg.sv
// Shared widths, pair tables and link type for the quad area block.
`default_nettype none
package qaas_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int NUM_PTS     = 4;
    localparam int NUM_PAIRS   = NUM_PTS * (NUM_PTS - 1) / 2;

    // centroid offsets 4*p - sum need two extra bits plus one for the difference
    localparam int D_WIDTH      = COORD_WIDTH + 3;
    localparam int DPROD_WIDTH  = 2 * D_WIDTH;
    localparam int DCROSS_WIDTH = 2 * D_WIDTH + 1;
    localparam int PPROD_WIDTH  = 2 * COORD_WIDTH;
    localparam int PCROSS_WIDTH = 2 * COORD_WIDTH + 1;
    localparam int AREA_WIDTH   = 2 * COORD_WIDTH + 3;

    // unordered point pairs, first index always the lower one
    localparam int PAIR_A [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [NUM_PAIRS] = '{1, 2, 3, 2, 3, 3};

    // per pair: fwd = B follows A in the sorted cycle, rev = A follows B
    typedef struct packed {
        logic [NUM_PAIRS-1:0] fwd;
        logic [NUM_PAIRS-1:0] rev;
    } t_link;

endpackage
`default_nettype wire

FILE: rtl/quad_area_angle_sorted_top.sv
// Top level: angle-sorted shoelace area of four Q12.12 points, 7-stage pipeline.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   input   | i_valid, o_stall, i_p1_x..i_p4_y | in
//   output  | o_valid, i_stall, o_signed_area  | out
//
// One item per cycle while o_stall is low; an accepted item passes stages A to G before o_valid.
// The depth is set by the offset, multiply, compare, rank and adder-tree stages.
// Synchronous active-low reset clears the stage valid bits only.
// A stalled result freezes the whole pipeline; o_stall follows i_stall
// while a result is held, and nothing is dropped or repeated.
`default_nettype none
module quad_area_angle_sorted_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p1_x,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p1_y,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p2_x,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p2_y,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p3_x,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p3_y,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p4_x,
    input  logic signed [qaas_pkg::COORD_WIDTH-1:0] i_p4_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [qaas_pkg::AREA_WIDTH-1:0]  o_signed_area
);

    localparam int CW  = qaas_pkg::COORD_WIDTH;
    localparam int NP  = qaas_pkg::NUM_PTS;
    localparam int NPR = qaas_pkg::NUM_PAIRS;
    localparam int DW  = qaas_pkg::D_WIDTH;
    localparam int DPW = qaas_pkg::DPROD_WIDTH;
    localparam int DCW = qaas_pkg::DCROSS_WIDTH;
    localparam int PPW = qaas_pkg::PPROD_WIDTH;
    localparam int PCW = qaas_pkg::PCROSS_WIDTH;
    localparam int AW  = qaas_pkg::AREA_WIDTH;

    typedef enum logic [1:0] {
        CLS_NEG_Y = 2'd0,   // dy < 0
        CLS_POS_X = 2'd1,   // dy == 0, dx >= 0, includes the centroid
        CLS_POS_Y = 2'd2,   // dy > 0
        CLS_NEG_X = 2'd3    // dy == 0, dx < 0
    } t_class;

    logic w_adv;

    // stage A: input capture
    logic                 r_a_valid;
    logic signed [CW-1:0] r_a_px [NP];
    logic signed [CW-1:0] r_a_py [NP];
    // stage B: centroid offsets
    logic                 r_b_valid;
    logic signed [CW-1:0] r_b_px [NP];
    logic signed [CW-1:0] r_b_py [NP];
    logic signed [DW-1:0] r_b_dx [NP];
    logic signed [DW-1:0] r_b_dy [NP];
    // stage C: classes and products
    logic                  r_c_valid;
    t_class                r_c_cls [NP];
    logic signed [DPW-1:0] r_c_dp1 [NPR];
    logic signed [DPW-1:0] r_c_dp2 [NPR];
    logic signed [PPW-1:0] r_c_pp1 [NPR];
    logic signed [PPW-1:0] r_c_pp2 [NPR];
    // stage D: angle order bits and pair cross terms
    logic                  r_d_valid;
    logic [NPR-1:0]        r_d_lt;
    logic signed [PCW-1:0] r_d_pc [NPR];
    // stage E: neighbor links
    logic                  r_e_valid;
    qaas_pkg::t_link       r_e_link;
    logic signed [PCW-1:0] r_e_pc [NPR];
    // stage F: partial sums
    logic                 r_f_valid;
    logic signed [AW-1:0] r_f_sum0;
    logic signed [AW-1:0] r_f_sum1;
    // stage G: output
    logic                 r_g_valid;
    logic signed [AW-1:0] r_g_area;

    logic signed [DW-1:0]  w_sx;
    logic signed [DW-1:0]  w_sy;
    logic [NPR-1:0]        n_d_lt;
    logic signed [AW-1:0]  w_term [NPR];
    qaas_pkg::t_link       w_link;

    assign o_stall       = r_g_valid & i_stall;
    assign w_adv         = ~o_stall;
    assign o_valid       = r_g_valid;
    assign o_signed_area = r_g_area;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
        end
    end

    // stage A
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_px[0] <= i_p1_x;
            r_a_py[0] <= i_p1_y;
            r_a_px[1] <= i_p2_x;
            r_a_py[1] <= i_p2_y;
            r_a_px[2] <= i_p3_x;
            r_a_py[2] <= i_p3_y;
            r_a_px[3] <= i_p4_x;
            r_a_py[3] <= i_p4_y;
        end
    end

    // stage B: d = 4*p - sum, exact in DW bits
    always_comb begin
        w_sx = '0;
        w_sy = '0;
        for (int i = 0; i < NP; i++) begin
            w_sx = w_sx + DW'(r_a_px[i]);
            w_sy = w_sy + DW'(r_a_py[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NP; i++) begin
                r_b_px[i] <= r_a_px[i];
                r_b_py[i] <= r_a_py[i];
                r_b_dx[i] <= (DW'(r_a_px[i]) <<< 2) - w_sx;
                r_b_dy[i] <= (DW'(r_a_py[i]) <<< 2) - w_sy;
            end
        end
    end

    // stage C
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < NP; i++) begin
                if (r_b_dy[i] < 0) begin
                    r_c_cls[i] <= CLS_NEG_Y;
                end else if (r_b_dy[i] > 0) begin
                    r_c_cls[i] <= CLS_POS_Y;
                end else if (r_b_dx[i] < 0) begin
                    r_c_cls[i] <= CLS_NEG_X;
                end else begin
                    r_c_cls[i] <= CLS_POS_X;
                end
            end
            for (int p = 0; p < NPR; p++) begin
                r_c_dp1[p] <= DPW'(r_b_dx[qaas_pkg::PAIR_A[p]]) *
                              DPW'(r_b_dy[qaas_pkg::PAIR_B[p]]);
                r_c_dp2[p] <= DPW'(r_b_dy[qaas_pkg::PAIR_A[p]]) *
                              DPW'(r_b_dx[qaas_pkg::PAIR_B[p]]);
                r_c_pp1[p] <= PPW'(r_b_px[qaas_pkg::PAIR_A[p]]) *
                              PPW'(r_b_py[qaas_pkg::PAIR_B[p]]);
                r_c_pp2[p] <= PPW'(r_b_px[qaas_pkg::PAIR_B[p]]) *
                              PPW'(r_b_py[qaas_pkg::PAIR_A[p]]);
            end
        end
    end

    // stage D: lt = angle(B) strictly below angle(A); cross(B,A) > 0 is cross(A,B) < 0
    always_comb begin
        logic signed [DCW-1:0] v_cross;
        t_class                v_ca;
        t_class                v_cb;
        for (int p = 0; p < NPR; p++) begin
            v_cross = DCW'(r_c_dp1[p]) - DCW'(r_c_dp2[p]);
            v_ca    = r_c_cls[qaas_pkg::PAIR_A[p]];
            v_cb    = r_c_cls[qaas_pkg::PAIR_B[p]];
            if (v_cb != v_ca) begin
                n_d_lt[p] = (v_cb < v_ca);
            end else begin
                n_d_lt[p] = (v_ca == CLS_NEG_Y || v_ca == CLS_POS_Y) && (v_cross < 0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_lt <= n_d_lt;
            for (int p = 0; p < NPR; p++) begin
                r_d_pc[p] <= PCW'(r_c_pp1[p]) - PCW'(r_c_pp2[p]);
            end
        end
    end

    // stage E
    qaas_link u_link (
        .i_lt   (r_d_lt),
        .o_link (w_link)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_link <= w_link;
            r_e_pc   <= r_d_pc;
        end
    end

    // stage F: each edge of the sorted cycle adds its cross term, reversed edges negate
    always_comb begin
        for (int p = 0; p < NPR; p++) begin
            if (r_e_link.fwd[p]) begin
                w_term[p] = AW'(r_e_pc[p]);
            end else if (r_e_link.rev[p]) begin
                w_term[p] = -AW'(r_e_pc[p]);
            end else begin
                w_term[p] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f_sum0 <= w_term[0] + w_term[1] + w_term[2];
            r_f_sum1 <= w_term[3] + w_term[4] + w_term[5];
        end
    end

    // stage G
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_g_area <= r_f_sum0 + r_f_sum1;
        end
    end

    // the cyclic order links exactly four of the six pairs, each in one direction
    a_link_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> ($countones(r_e_link.fwd | r_e_link.rev) == NP &&
                       (r_e_link.fwd & r_e_link.rev) == '0))
        else $error("neighbor links do not form a cycle");

    a_stall_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result held");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f_valid && w_adv) |=> o_valid)
        else $error("item lost before output");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_f_valid))
        else $error("result without an item behind it");

endmodule
`default_nettype wire

FILE: rtl/qaas_link.sv
// Stable ranks from pairwise angle order, and cyclic neighbor flags per pair.
`default_nettype none
module qaas_link (
    input  logic [qaas_pkg::NUM_PAIRS-1:0] i_lt,   // per pair: angle(B) < angle(A)
    output qaas_pkg::t_link                o_link
);

    logic [1:0] w_rank [qaas_pkg::NUM_PTS];

    // rank of a point = earlier points not after it + later points before it
    always_comb begin
        for (int i = 0; i < qaas_pkg::NUM_PTS; i++) begin
            w_rank[i] = 2'd0;
        end
        for (int p = 0; p < qaas_pkg::NUM_PAIRS; p++) begin
            if (i_lt[p]) begin
                w_rank[qaas_pkg::PAIR_A[p]] = w_rank[qaas_pkg::PAIR_A[p]] + 2'd1;
            end else begin
                w_rank[qaas_pkg::PAIR_B[p]] = w_rank[qaas_pkg::PAIR_B[p]] + 2'd1;
            end
        end
    end

    always_comb begin
        for (int p = 0; p < qaas_pkg::NUM_PAIRS; p++) begin
            o_link.fwd[p] = (w_rank[qaas_pkg::PAIR_B[p]] ==
                             w_rank[qaas_pkg::PAIR_A[p]] + 2'd1);
            o_link.rev[p] = (w_rank[qaas_pkg::PAIR_A[p]] ==
                             w_rank[qaas_pkg::PAIR_B[p]] + 2'd1);
        end
    end

endmodule
`default_nettype wire
